@@ src/weighted_box_filter_3x3_defines.svh @@
// Assertion macros shared by the weighted box filter RTL.
`ifndef WEIGHTED_BOX_FILTER_3X3_DEFINES_SVH
`define WEIGHTED_BOX_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, sampled at the rising edge, off while in reset.
`define WBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled at the rising edge, off while in reset.
`define WBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/wbf_pkg.sv @@
// Shared constants, types and helper functions of the weighted box filter.
package wbf_pkg;

	localparam int PIX_W        = 8;
	localparam int KSIZE        = 3;
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MIN_DIM      = 3;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int WEIGHT_W     = 8;
	localparam int WEIGHTS_W    = 64;

	// arithmetic widths
	localparam int PROD_W    = PIX_W + WEIGHT_W;
	localparam int COLSUM_W  = PROD_W + 2;
	localparam int SUM_W     = PROD_W + 4;
	localparam int DIVISOR   = 9;
	localparam int DIV_SHIFT = 23;
	localparam int RECIP     = (2 ** DIV_SHIFT + DIVISOR - 1) / DIVISOR;
	localparam int RECIP_W   = $clog2(RECIP + 1);
	localparam int MUL_W     = SUM_W + RECIP_W;
	localparam int QUOT_W    = MUL_W - DIV_SHIFT;
	localparam int PIX_MAX   = 255;

	// result queue, depth must be a power of two
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// register port
	localparam int APB_DW  = 64;
	localparam int REG_LSB = 3;
	localparam int APB_AW  = REG_LSB + 2;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST   = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST  = HEIGHT_REG_W'(480);
	localparam logic [WEIGHTS_W-1:0]    WEIGHTS_RST = 64'h0101_0101_0101_0101;
	localparam logic [WEIGHT_W-1:0]     WLAST_RST   = WEIGHT_W'(1);

	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_WEIGHTS,
		REG_WEIGHT_LAST
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [KSIZE-1:0][PIX_W-1:0] col_t;       // index 0 = top row
	typedef logic [KSIZE-1:0][WEIGHT_W-1:0] wcol_t;
	typedef logic [KSIZE-1:0][PROD_W-1:0] prod_col_t;

	typedef struct packed {
		pix_t older;
		pix_t newer;
	} line_word_t;

	typedef struct packed {
		pix_t smoothed;
		logic frame_end;
	} res_t;

	// last column index for a programmed width, clamped to the legal range
	function automatic logic [COL_W-1:0] width_last(logic [WIDTH_REG_W-1:0] v);
		logic [COL_W-1:0] r;
		if (int'(v) < MIN_DIM) begin
			r = COL_W'(MIN_DIM - 1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = COL_W'(MAX_WIDTH - 1);
		end else begin
			r = COL_W'(v - 1'b1);
		end
		return r;
	endfunction

	// last row index for a programmed height, clamped to the legal range
	function automatic logic [ROW_W-1:0] height_last(logic [HEIGHT_REG_W-1:0] v);
		logic [ROW_W-1:0] r;
		if (int'(v) < MIN_DIM) begin
			r = ROW_W'(MIN_DIM - 1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			r = ROW_W'(v - 1'b1);
		end
		return r;
	endfunction

endpackage

@@ src/wbf_if.sv @@
// Valid/ready stream interfaces for the pixel input and the result output.
interface wbf_in_if
	import wbf_pkg::*;
();
	logic valid;
	logic ready;
	logic mode;
	pix_t pixel;

	modport source(output valid, output mode, output pixel, input ready);
	modport sink(input valid, input mode, input pixel, output ready);
endinterface

interface wbf_out_if
	import wbf_pkg::*;
();
	logic valid;
	logic ready;
	pix_t smoothed;
	logic frame_end;

	modport source(output valid, output smoothed, output frame_end, input ready);
	modport sink(input valid, input smoothed, input frame_end, output ready);
endinterface

@@ src/wbf_line_ram.sv @@
// Simple dual-port RAM, registered read, write data forwarded on address match.
module wbf_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr == raddr) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/wbf_cell.sv @@
// One window column: holds three pixels, shifts left, forms its weighted products.
module wbf_cell import wbf_pkg::*; (
	input  logic      clk,
	input  logic      shift,
	input  col_t      col_in,
	input  wcol_t     wt,
	output col_t      col_out,
	output prod_col_t prod
);

	col_t      col_q;
	prod_col_t prod_s3;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < KSIZE; r++) begin
			prod_s3[r] <= PROD_W'(col_q[r]) * PROD_W'(wt[r]);
		end
	end

	assign col_out = col_q;
	assign prod    = prod_s3;

endmodule

@@ src/wbf_out_fifo.sv @@
// Small result queue between the filter pipeline and the output channel.
`include "weighted_box_filter_3x3_defines.svh"

module wbf_out_fifo import wbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic valid,
	output res_t data
);

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
		end
	end

	assign valid = cnt_q != '0;
	assign data  = mem_q[rd_ptr_q];

	`WBF_ASSERT_NOW(a_no_overflow, clk, arst_n, push, (cnt_q < (FIFO_AW + 1)'(FIFO_DEPTH)) || pop, "result queue overflow")
	`WBF_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, cnt_q != '0, "result queue underflow")

endmodule

@@ src/weighted_box_filter_3x3.sv @@
// Top level of the 3x3 weighted box filter: counters, line RAM, window cells, divider, queue.
// A result is pushed into the queue from stage 5, once its window total is registered.
// Throughput: one item per cycle; ready drops only while 8 results are outstanding.
// The pipeline holds the line RAM read, the product stage, two adder levels and the 1/9 multiply.
// Reset (arst_n, async): counters clear, registers take defaults; line RAM is not cleared.
`include "weighted_box_filter_3x3_defines.svh"

module weighted_box_filter_3x3 import wbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	wbf_in_if.sink            pix,
	wbf_out_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// where a result's value comes from
	typedef enum logic [1:0] {
		SRC_LAST_OLDER,   // last column of the line two rows up (right border)
		SRC_NEWER,        // newer line store entry (bottom row while draining)
		SRC_CENTER,       // window center (border pixel passes through)
		SRC_FILTER        // weighted mean of the window
	} src_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WEIGHTS_W-1:0]    weights_q;
	logic [WEIGHT_W-1:0]     wlast_q;
	logic [COL_W-1:0]        w_last_q;   // clamped width - 1
	logic [ROW_W-1:0]        h_last_q;   // clamped height - 1

	reg_idx_t cfg_idx;
	logic     cfg_wr;
	logic     restart_cfg;

	assign pready      = 1'b1;
	assign cfg_idx     = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);
	assign cfg_wr      = psel && penable && pwrite;
	// a new geometry starts a fresh frame
	assign restart_cfg = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			weights_q <= WEIGHTS_RST;
			wlast_q   <= WLAST_RST;
			w_last_q  <= width_last(WIDTH_RST);
			h_last_q  <= height_last(HEIGHT_RST);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH: begin
					width_q  <= pwdata[WIDTH_REG_W-1:0];
					w_last_q <= width_last(pwdata[WIDTH_REG_W-1:0]);
				end
				REG_HEIGHT: begin
					height_q <= pwdata[HEIGHT_REG_W-1:0];
					h_last_q <= height_last(pwdata[HEIGHT_REG_W-1:0]);
				end
				REG_WEIGHTS:     weights_q <= pwdata[WEIGHTS_W-1:0];
				REG_WEIGHT_LAST: wlast_q   <= pwdata[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:       prdata = APB_DW'(width_q);
			REG_HEIGHT:      prdata = APB_DW'(height_q);
			REG_WEIGHTS:     prdata = APB_DW'(weights_q);
			REG_WEIGHT_LAST: prdata = APB_DW'(wlast_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 0: position counters, decided at the input transfer
	// ------------------------------------------------------------------
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             frame_done_q;
	logic [FIFO_AW:0] pend_q;        // accepted items that still owe a result

	logic             acc;
	logic             is_drain;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] row_c;
	logic [COL_W-1:0] ocol_c;
	logic [ROW_W-1:0] orow_c;
	logic             col_last_c;
	logic             row_last_c;
	logic             pix_emit_c;
	logic             border_c;
	logic             emit_c;
	logic             frame_end_c;
	logic [COL_W-1:0] raddr_c;
	src_t             src_c;
	logic             res_pop;

	assign acc     = pix.valid && pix.ready;
	assign res_pop = res.valid && res.ready;

	always_comb begin
		is_drain = pix.mode == MODE_DRAIN;
		// a pixel after a finished frame starts the next one
		col_c  = frame_done_q ? '0 : in_col_q;
		row_c  = frame_done_q ? '0 : in_row_q;
		ocol_c = frame_done_q ? '0 : out_col_q;
		orow_c = frame_done_q ? '0 : out_row_q;
		col_last_c = col_c == w_last_q;
		row_last_c = row_c == h_last_q;
		// output trails by one line and one pixel
		pix_emit_c = (row_c > ROW_W'(1)) || (row_c == ROW_W'(1) && col_c != '0);
		border_c   = orow_c == '0 || orow_c == h_last_q || ocol_c == '0 || ocol_c == w_last_q;
		emit_c     = is_drain ? frame_done_q : pix_emit_c;
		frame_end_c = is_drain && frame_done_q && out_col_q == w_last_q
			&& out_row_q == h_last_q;
		raddr_c = is_drain ? out_col_q : col_c;
		if (is_drain) begin
			src_c = (out_row_q == h_last_q) ? SRC_NEWER : SRC_LAST_OLDER;
		end else if (col_c == '0) begin
			src_c = SRC_LAST_OLDER;
		end else if (border_c) begin
			src_c = SRC_CENTER;
		end else begin
			src_c = SRC_FILTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			frame_done_q <= 1'b0;
		end else if (restart_cfg) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			frame_done_q <= 1'b0;
		end else if (acc) begin
			if (is_drain) begin
				if (frame_done_q) begin
					if (out_col_q == w_last_q) begin
						out_col_q <= '0;
						if (out_row_q == h_last_q) begin
							// last pending result gone: frame closed
							out_row_q    <= '0;
							frame_done_q <= 1'b0;
						end else begin
							out_row_q <= out_row_q + 1'b1;
						end
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end else begin
				if (col_last_c) begin
					in_col_q <= '0;
					in_row_q <= row_last_c ? '0 : row_c + 1'b1;
				end else begin
					in_col_q <= col_c + 1'b1;
					in_row_q <= row_c;
				end
				frame_done_q <= col_last_c && row_last_c;
				if (pix_emit_c) begin
					if (ocol_c == w_last_q) begin
						out_col_q <= '0;
						out_row_q <= orow_c + 1'b1;
					end else begin
						out_col_q <= ocol_c + 1'b1;
						out_row_q <= orow_c;
					end
				end else begin
					out_col_q <= ocol_c;
					out_row_q <= orow_c;
				end
			end
		end
	end

	// credit count keeps the result queue from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (FIFO_AW + 1)'(acc && emit_c) - (FIFO_AW + 1)'(res_pop);
		end
	end

	assign pix.ready = pend_q < (FIFO_AW + 1)'(FIFO_DEPTH);

	// ------------------------------------------------------------------
	// Stage 1: line RAM data back, write back, window shift
	// ------------------------------------------------------------------
	logic             pixv_s1;
	logic             emit_s1;
	logic [COL_W-1:0] col_s1;
	logic             col_last_s1;
	pix_t             pix_s1;
	src_t             src_s1;
	logic             fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixv_s1 <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			pixv_s1 <= acc && !is_drain;
			emit_s1 <= acc && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		col_s1      <= col_c;
		col_last_s1 <= col_last_c;
		pix_s1      <= pix.pixel;
		src_s1      <= src_c;
		fe_s1       <= frame_end_c;
	end

	line_word_t rd_word;
	line_word_t wr_word;
	logic [2*PIX_W-1:0] rd_raw;
	pix_t       last_older_q;    // older line entry of the last column

	assign rd_word       = line_word_t'(rd_raw);
	assign wr_word.older = rd_word.newer;
	assign wr_word.newer = pix_s1;

	wbf_line_ram #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(2 * PIX_W)
	) u_line_ram (
		.clk  (clk),
		.we   (pixv_s1),
		.waddr(col_s1),
		.wdata(wr_word),
		.raddr(raddr_c),
		.rdata(rd_raw)
	);

	always_ff @(posedge clk) begin
		if (pixv_s1 && col_last_s1) begin
			last_older_q <= rd_word.newer;
		end
	end

	// window: new column enters the rightmost cell, moves left each pixel
	col_t                                    new_col;
	col_t                                    cell_in  [KSIZE];
	col_t                                    cell_out [KSIZE];
	wcol_t                                   cell_wt  [KSIZE];
	prod_col_t                               cell_prod[KSIZE];
	logic [KSIZE*KSIZE-1:0][WEIGHT_W-1:0]    wt;

	assign new_col[0] = rd_word.older;
	assign new_col[1] = rd_word.newer;
	assign new_col[2] = pix_s1;
	assign wt         = {wlast_q, weights_q};

	for (genvar c = 0; c < KSIZE; c++) begin : g_cells
		if (c == KSIZE - 1) begin : g_head
			assign cell_in[c] = new_col;
		end else begin : g_link
			assign cell_in[c] = cell_out[c + 1];
		end

		always_comb begin
			for (int r = 0; r < KSIZE; r++) begin
				cell_wt[c][r] = wt[r * KSIZE + c];
			end
		end

		wbf_cell u_cell (
			.clk    (clk),
			.shift  (pixv_s1),
			.col_in (cell_in[c]),
			.wt     (cell_wt[c]),
			.col_out(cell_out[c]),
			.prod   (cell_prod[c])
		);
	end

	// ------------------------------------------------------------------
	// Stage 2: window valid, products formed in the cells
	// ------------------------------------------------------------------
	logic emit_s2;
	src_t src_s2;
	pix_t byp_s2;
	logic fe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		src_s2 <= src_s1;
		byp_s2 <= (src_s1 == SRC_NEWER) ? rd_word.newer : last_older_q;
		fe_s2  <= fe_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: products registered, pass-through value settled
	// ------------------------------------------------------------------
	logic emit_s3;
	logic filt_s3;
	pix_t val_s3;
	logic fe_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= 1'b0;
		end else begin
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		filt_s3 <= src_s2 == SRC_FILTER;
		val_s3  <= (src_s2 == SRC_CENTER) ? cell_out[KSIZE / 2][KSIZE / 2] : byp_s2;
		fe_s3   <= fe_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: column sums
	// ------------------------------------------------------------------
	logic [COLSUM_W-1:0] colsum_c [KSIZE];
	logic [COLSUM_W-1:0] colsum_s4[KSIZE];
	logic                emit_s4;
	logic                filt_s4;
	pix_t                val_s4;
	logic                fe_s4;

	always_comb begin
		for (int c = 0; c < KSIZE; c++) begin
			colsum_c[c] = '0;
			for (int r = 0; r < KSIZE; r++) begin
				colsum_c[c] = colsum_c[c] + COLSUM_W'(cell_prod[c][r]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s4 <= 1'b0;
		end else begin
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		colsum_s4 <= colsum_c;
		filt_s4   <= filt_s3;
		val_s4    <= val_s3;
		fe_s4     <= fe_s3;
	end

	// ------------------------------------------------------------------
	// Stage 5: window total; divide by 9 and saturate into the queue
	// ------------------------------------------------------------------
	logic [SUM_W-1:0]  sum_c;
	logic [SUM_W-1:0]  sum_s5;
	logic              emit_s5;
	logic              filt_s5;
	pix_t              val_s5;
	logic              fe_s5;
	logic [MUL_W-1:0]  mul_c;
	logic [QUOT_W-1:0] quot_c;
	pix_t              sat_c;
	res_t              push_data;
	res_t              fifo_data;

	always_comb begin
		sum_c = '0;
		for (int c = 0; c < KSIZE; c++) begin
			sum_c = sum_c + SUM_W'(colsum_s4[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s5 <= 1'b0;
		end else begin
			emit_s5 <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		sum_s5  <= sum_c;
		filt_s5 <= filt_s4;
		val_s5  <= val_s4;
		fe_s5   <= fe_s4;
	end

	// reciprocal multiply is exact for every sum below 2^SUM_W
	always_comb begin
		mul_c  = MUL_W'(sum_s5) * MUL_W'(RECIP);
		quot_c = mul_c[MUL_W-1:DIV_SHIFT];
		sat_c  = (quot_c > QUOT_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : quot_c[PIX_W-1:0];
		push_data.smoothed  = filt_s5 ? sat_c : val_s5;
		push_data.frame_end = fe_s5;
	end

	wbf_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit_s5),
		.push_data(push_data),
		.pop      (res_pop),
		.valid    (res.valid),
		.data     (fifo_data)
	);

	assign res.smoothed  = fifo_data.smoothed;
	assign res.frame_end = fifo_data.frame_end;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`WBF_ASSERT_NOW(a_in_pos_range, clk, arst_n, 1'b1, in_col_q <= w_last_q && in_row_q <= h_last_q, "input position outside frame")
	`WBF_ASSERT_NOW(a_out_pos_range, clk, arst_n, 1'b1, out_col_q <= w_last_q && out_row_q <= h_last_q, "output position outside frame")
	`WBF_ASSERT_NEXT(a_frame_close, clk, arst_n, acc && frame_end_c, !frame_done_q && out_col_q == '0 && out_row_q == '0, "frame not closed after its last result")
	`WBF_ASSERT_NOW(a_res_counted, clk, arst_n, res.valid, pend_q != '0, "result offered without a pending credit")

endmodule
